// ===== hw/rtl/isort_pkg.sv =====
// shared types and constants for the insertion sorter
package isort_pkg;

    localparam int MAX_COUNT  = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(MAX_COUNT + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]             t_cnt;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;    // insert the broadcast key
        logic shift;  // move contents one place toward cell 0
    } t_cell_ctl;

endpackage

// ===== hw/rtl/insertion_sorter_core.sv =====
// streaming insertion sorter: chain of compare-and-shift cells plus emit control
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+----------------------------------------
//  input    | i_in_valid  | o_in_stall  | i_value, i_final_req
//  output   | o_out_valid | i_out_stall | o_sorted_value, o_end_of_set, o_overflow
//
// every element is inserted in the cycle it is accepted unless the store is full, one per cycle while not stalled
// after a final element the set drains from cell 0, one result per cycle while
// the output register is free; the input stalls until the whole set (1..MAX_COUNT
// entries) has drained through the single-entry shift toward cell 0
// reset (synchronous, active low) empties the store and the output register
module insertion_sorter_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  isort_pkg::t_data         i_value,
    input  logic                     i_final_req,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output isort_pkg::t_data         o_sorted_value,
    output logic                     o_end_of_set,
    output logic                     o_overflow
);
    import isort_pkg::*;

    localparam t_cnt FULL = CNT_W'(MAX_COUNT);
    localparam t_cnt ONE  = CNT_W'(1);

    // control state
    t_cnt  r_count, n_count;     // entries held; counts down while draining
    logic  r_dropped, n_dropped; // an element of this set was discarded
    logic  r_emit, n_emit;       // draining the store
    logic  r_out_valid, n_out_valid;

    // output payload register
    t_data r_out_data;
    logic  r_out_end;
    logic  r_out_ovf;

    logic      in_acc;
    logic      full;
    logic      out_free;
    logic      emit_go;
    t_cell_ctl ctl;

    // chain wiring
    t_data cell_data [MAX_COUNT];
    logic  cell_move [MAX_COUNT];
    logic  cell_occ  [MAX_COUNT];

    assign in_acc   = i_in_valid && !o_in_stall;
    assign full     = (r_count == FULL);
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit_go  = r_emit && out_free;

    // a full store drops the element but still counts it for overflow
    assign ctl.ins   = in_acc && !full;
    assign ctl.shift = emit_go;

    genvar g;
    generate
        for (g = 0; g < MAX_COUNT; g++) begin : g_cell
            t_data prev_data;
            t_data next_data;
            logic  prev_move;

            assign cell_occ[g] = (CNT_W'(g) < r_count);

            if (g == 0) begin : g_first
                assign prev_move = 1'b0;
                assign prev_data = i_value;
            end else begin : g_mid
                assign prev_move = cell_move[g-1];
                assign prev_data = cell_data[g-1];
            end

            if (g == MAX_COUNT - 1) begin : g_last
                assign next_data = cell_data[g];
            end else begin : g_body
                assign next_data = cell_data[g+1];
            end

            isort_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_key       (i_value),
                .i_occ       (cell_occ[g]),
                .i_prev_move (prev_move),
                .i_prev_data (prev_data),
                .i_next_data (next_data),
                .o_move      (cell_move[g]),
                .o_data      (cell_data[g])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_emit      = r_emit;
        n_out_valid = r_out_valid;

        if (in_acc) begin
            if (full) begin
                n_dropped = 1'b1;
            end else begin
                n_count = r_count + ONE;
            end
            // a final element always leaves at least one entry to send
            if (i_final_req) begin
                n_emit = 1'b1;
            end
        end

        if (emit_go) begin
            n_out_valid = 1'b1;
            n_count     = r_count - ONE;
            if (r_count == ONE) begin
                n_emit    = 1'b0;
                n_dropped = 1'b0;
            end
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload comes straight off the bottom of the chain
    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_data <= cell_data[0];
            r_out_end  <= (r_count == ONE);
            r_out_ovf  <= r_dropped;
        end
    end

    // no new requests while a set drains
    assign o_in_stall     = r_emit;
    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_data;
    assign o_end_of_set   = r_out_end;
    assign o_overflow     = r_out_ovf;

endmodule

// ===== hw/rtl/isort_cell.sv =====
// one cell of the sorting chain: holds one entry, trades with its neighbors
module isort_cell (
    input  logic               i_clk,
    input  isort_pkg::t_cell_ctl i_ctl,
    input  isort_pkg::t_data   i_key,
    input  logic               i_occ,
    input  logic               i_prev_move,
    input  isort_pkg::t_data   i_prev_data,
    input  isort_pkg::t_data   i_next_data,
    output logic               o_move,
    output isort_pkg::t_data   o_data
);
    import isort_pkg::*;

    t_data r_data;
    logic  ge;
    logic  take;

    // entries >= key move up one place; empty cells always accept
    assign ge     = (r_data >= i_key);
    assign o_move = i_occ && ge;
    assign take   = !i_occ || ge;
    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && take) begin
            r_data <= i_prev_move ? i_prev_data : i_key;
        end else if (i_ctl.shift) begin
            r_data <= i_next_data;
        end
    end

endmodule

// ===== hw/rtl/isort_checker.sv =====
// port-level checks for the insertion sorter, bound to the top level
module isort_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             i_final_req,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input isort_pkg::t_data o_sorted_value,
    input logic             o_end_of_set,
    input logic             o_overflow
);
    import isort_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sorted_value))
        else $error("stalled result changed");

    // a final request starts a drain
    a_final_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_final_req |=> o_in_stall)
        else $error("no drain after final request");

    // mid-set results only appear while the input is held off
    a_mid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_end_of_set |-> o_in_stall)
        else $error("input open while set not finished");

    // overflow is constant across one set
    a_ovf_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_end_of_set |=>
            !o_out_valid || (o_overflow == $past(o_overflow)))
        else $error("overflow flag changed within a set");

endmodule

bind insertion_sorter_core isort_checker u_isort_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_final_req    (i_final_req),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_sorted_value (o_sorted_value),
    .o_end_of_set   (o_end_of_set),
    .o_overflow     (o_overflow)
);
